@@ hdl/smstep_pkg.sv @@
package smstep_pkg;

    localparam int CODE_AW  = 10;
    localparam int STK_AW   = 8;
    localparam int STK_DW   = 9;
    localparam int RS_AW    = 6;
    localparam int RS_DW    = 7;
    localparam int REG_AW   = 3;
    localparam int NUM_REGS = 8;
    localparam int RAM_AW   = 8;
    localparam int RAM_WORDS = 256;

    localparam logic [1:0] REQ_WRITE   = 2'd0;
    localparam logic [1:0] REQ_EXEC    = 2'd1;
    localparam logic [1:0] REQ_RESTART = 2'd2;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_UNDER = 3'd1;
    localparam logic [2:0] ST_OVER  = 3'd2;
    localparam logic [2:0] ST_DIV0  = 3'd3;
    localparam logic [2:0] ST_BAD   = 3'd4;
    localparam logic [2:0] ST_CALL  = 3'd5;

    localparam logic [4:0] OP_HLT  = 5'd0;
    localparam logic [4:0] OP_PUSH = 5'd1;
    localparam logic [4:0] OP_POP  = 5'd2;
    localparam logic [4:0] OP_ADD  = 5'd3;
    localparam logic [4:0] OP_SUB  = 5'd4;
    localparam logic [4:0] OP_DIV  = 5'd5;
    localparam logic [4:0] OP_MUL  = 5'd6;
    localparam logic [4:0] OP_SQRT = 5'd7;
    localparam logic [4:0] OP_SIN  = 5'd8;
    localparam logic [4:0] OP_COS  = 5'd9;
    localparam logic [4:0] OP_OUT  = 5'd10;
    localparam logic [4:0] OP_IN   = 5'd11;
    localparam logic [4:0] OP_DUMP = 5'd12;
    localparam logic [4:0] OP_JMP  = 5'd13;
    localparam logic [4:0] OP_JA   = 5'd14;
    localparam logic [4:0] OP_JAE  = 5'd15;
    localparam logic [4:0] OP_JB   = 5'd16;
    localparam logic [4:0] OP_JBE  = 5'd17;
    localparam logic [4:0] OP_JE   = 5'd18;
    localparam logic [4:0] OP_JNE  = 5'd19;
    localparam logic [4:0] OP_CALL = 5'd20;
    localparam logic [4:0] OP_RET  = 5'd21;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_EXEC,
        S_RAMRD,
        S_ITER,
        S_RESP
    } fsm_t;

    typedef struct packed {
        logic start;
        logic is_sqrt;
    } iter_ctl_t;

endpackage

@@ hdl/smstep_iter.sv @@
// Shared multi-cycle unit: signed truncating divide (32 steps) or floor sqrt (16 steps).
module smstep_iter
    import smstep_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  iter_ctl_t   ctl,
    input  logic [31:0] opa,
    input  logic [31:0] opb,
    output logic        done,
    output logic [31:0] result
);

    logic        busy_reg, done_reg, sqrt_reg, neg_reg;
    logic [5:0]  cnt_reg;
    logic [31:0] acc_reg, quo_reg, div_reg;
    logic [32:0] rem_reg;
    logic [31:0] acc_next, quo_next;
    logic [32:0] rem_next;
    logic [32:0] rem_sh, trial;

    always_comb
    begin
        if (sqrt_reg)
        begin
            rem_sh   = {rem_reg[30:0], acc_reg[31:30]};
            trial    = {quo_reg[30:0], 2'b01};
            acc_next = {acc_reg[29:0], 2'b00};
        end
        else
        begin
            rem_sh   = {rem_reg[31:0], acc_reg[31]};
            trial    = {1'b0, div_reg};
            acc_next = {acc_reg[30:0], 1'b0};
        end
        if (rem_sh >= trial)
        begin
            rem_next = rem_sh - trial;
            quo_next = {quo_reg[30:0], 1'b1};
        end
        else
        begin
            rem_next = rem_sh;
            quo_next = {quo_reg[30:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (ctl.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= ctl.is_sqrt ? 6'd16 : 6'd32;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            sqrt_reg <= ctl.is_sqrt;
            neg_reg  <= opa[31] ^ opb[31];
            acc_reg  <= (!ctl.is_sqrt && opa[31]) ? -opa : opa;
            div_reg  <= opb[31] ? -opb : opb;
            rem_reg  <= '0;
            quo_reg  <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done   = done_reg;
    assign result = (!sqrt_reg && neg_reg) ? -quo_reg : quo_reg;

endmodule

@@ hdl/stack_machine_step_unit.sv @@
// Stack machine step unit.
// Input channel (in_valid/in_ready) moves one request per transfer: write a
// code word, execute one instruction at the current instruction pointer, or
// restart at entry_ip with both stacks emptied. Every request yields exactly
// one result transfer on res_valid/res_ready carrying out_valid, out_value,
// halted, status and next_ip.
// entry_ip is loaded through cfg_we/cfg_wdata; the user must do so only while
// the unit is idle, as the block does not enforce it. One request is in flight
// at a time. Code write, restart and a request to a halted machine go straight
// to the result state. An execute reads four code words and the stack tops from
// registered-read memories in S_FETCH and decodes and commits in S_EXEC; a RAM
// operand adds S_RAMRD, and div and sqrt wait in S_ITER on the shared unit.
// Reset empties both stacks, clears registers, RAM (valid bits), ip, status.
// While the receiver stalls the result is held and no request is taken.
module stack_machine_step_unit
    import smstep_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [9:0]  cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  req_type,
    input  logic [9:0]  code_addr,
    input  logic [31:0] code_word,
    input  logic [31:0] in_value,
    output logic        res_valid,
    input  logic        res_ready,
    output logic        out_valid,
    output logic [31:0] out_value,
    output logic        halted,
    output logic [2:0]  status,
    output logic [9:0]  next_ip
);

    fsm_t state_reg, state_next;
    logic [2:0]         cnt_reg;
    logic [CODE_AW-1:0] ip_reg, entry_reg;
    logic [STK_DW-1:0]  d_reg;
    logic [RS_DW-1:0]   rd_reg;
    logic               stopped_reg;
    logic [2:0]         status_reg;
    logic [31:0]        inv_reg;
    logic [31:0]        w_reg [4];
    logic [31:0]        top_reg, sec_reg;
    logic [CODE_AW-1:0] rtop_reg;
    logic [31:0]        gp_reg [NUM_REGS];
    logic               ov_reg;
    logic [31:0]        oval_reg;
    logic [RAM_WORDS-1:0] ram_vld_reg;

    // memories
    logic [31:0]        code_mem [1 << CODE_AW];
    logic [31:0]        stk_mem  [1 << STK_AW];
    logic [CODE_AW-1:0] rs_mem   [1 << RS_AW];
    logic [31:0]        ram_mem  [RAM_WORDS];
    logic [31:0]        code_q, stk_q, ram_q;
    logic [CODE_AW-1:0] rs_q;
    logic               ram_vq;

    logic accept, commit;
    logic [CODE_AW-1:0] code_raddr;
    logic [STK_AW-1:0]  stk_raddr;
    logic [31:0]        stk_wdata, ram_val;

    // decode results
    logic [2:0]         x_err;
    logic               x_halt, x_need_ram, x_need_iter, x_sqrt;
    logic               x_stk_we, x_rs_we, x_gp_we, x_ram_we, x_ov;
    logic [STK_AW-1:0]  x_stk_addr;
    logic [31:0]        x_val;
    logic [STK_DW-1:0]  x_depth;
    logic [CODE_AW-1:0] x_ip;
    logic [RS_DW-1:0]   x_rd;

    // operand decode
    logic [31:0]        kind, regword, gval;
    logic [33:0]        opsum;
    logic               idx_bad, ram_bad, opnd_bad, take, tgt_bad;
    logic [2:0]         op_len;
    logic [REG_AW-1:0]  ridx;

    iter_ctl_t   iter_ctl;
    logic        iter_done;
    logic [31:0] iter_res;

    assign accept    = in_valid && in_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_RESP);
    assign out_valid = ov_reg;
    assign out_value = oval_reg;
    assign halted    = stopped_reg;
    assign status    = status_reg;
    assign next_ip   = ip_reg;

    // operand words: kind, optional constant, optional register index
    always_comb
    begin
        kind    = w_reg[1];
        regword = kind[0] ? w_reg[3] : w_reg[2];
        ridx    = regword[REG_AW-1:0];
        gval    = gp_reg[ridx];
        idx_bad = kind[1] && (regword[31:REG_AW] != '0);
        opsum   = (kind[0] ? {{2{w_reg[2][31]}}, w_reg[2]} : 34'd0)
                + (kind[1] ? {{2{gval[31]}}, gval} : 34'd0);
        ram_bad = kind[2] && (opsum[33] || (opsum[32:RAM_AW] != '0));
        opnd_bad = idx_bad || ram_bad;
        op_len  = 3'd2 + {2'b00, kind[0]} + {2'b00, kind[1]};
        tgt_bad = (w_reg[1][31:CODE_AW] != '0);
        unique case (w_reg[0][4:0])
            OP_JA:   take = $signed(sec_reg) >  $signed(top_reg);
            OP_JAE:  take = $signed(sec_reg) >= $signed(top_reg);
            OP_JB:   take = $signed(sec_reg) <  $signed(top_reg);
            OP_JBE:  take = $signed(sec_reg) <= $signed(top_reg);
            OP_JE:   take = sec_reg == top_reg;
            default: take = sec_reg != top_reg;
        endcase
    end

    // instruction decode; stable from S_EXEC until commit
    always_comb
    begin
        x_err       = ST_OK;
        x_halt      = 1'b0;
        x_need_ram  = 1'b0;
        x_need_iter = 1'b0;
        x_sqrt      = 1'b0;
        x_stk_we    = 1'b0;
        x_rs_we     = 1'b0;
        x_gp_we     = 1'b0;
        x_ram_we    = 1'b0;
        x_ov        = 1'b0;
        x_stk_addr  = d_reg[STK_AW-1:0];
        x_val       = '0;
        x_depth     = d_reg;
        x_ip        = ip_reg + CODE_AW'(1);
        x_rd        = rd_reg;
        if (w_reg[0][31:5] != '0)
        begin
            x_err = ST_BAD;
        end
        else
        begin
            unique case (w_reg[0][4:0])
                OP_HLT:
                begin
                    x_halt = 1'b1;
                    x_ip   = ip_reg;
                end
                OP_PUSH:
                begin
                    if (opnd_bad)
                        x_err = ST_BAD;
                    else if (d_reg[STK_DW-1])
                        x_err = ST_OVER;
                    else
                    begin
                        x_need_ram = kind[2];
                        x_stk_we   = 1'b1;
                        x_val      = opsum[31:0];
                        x_depth    = d_reg + STK_DW'(1);
                        x_ip       = ip_reg + CODE_AW'(op_len);
                    end
                end
                OP_POP:
                begin
                    if (d_reg == '0)
                        x_err = ST_UNDER;
                    else if (opnd_bad || (!kind[2] && !kind[1]))
                        x_err = ST_BAD;
                    else
                    begin
                        x_ram_we = kind[2];
                        x_gp_we  = !kind[2];
                        x_depth  = d_reg - STK_DW'(1);
                        x_ip     = ip_reg + CODE_AW'(op_len);
                    end
                end
                OP_ADD, OP_SUB, OP_MUL, OP_DIV:
                begin
                    if (d_reg < STK_DW'(2))
                        x_err = ST_UNDER;
                    else if (w_reg[0][4:0] == OP_DIV && top_reg == '0)
                        x_err = ST_DIV0;
                    else
                    begin
                        x_stk_we   = 1'b1;
                        x_stk_addr = d_reg[STK_AW-1:0] - STK_AW'(2);
                        x_depth    = d_reg - STK_DW'(1);
                        x_need_iter = (w_reg[0][4:0] == OP_DIV);
                        if (w_reg[0][4:0] == OP_ADD)
                            x_val = sec_reg + top_reg;
                        else if (w_reg[0][4:0] == OP_SUB)
                            x_val = sec_reg - top_reg;
                        else
                            x_val = sec_reg * top_reg;
                    end
                end
                OP_SQRT, OP_SIN, OP_COS:
                begin
                    if (d_reg == '0)
                        x_err = ST_UNDER;
                    else if (w_reg[0][4:0] == OP_SQRT && top_reg[31])
                        x_err = ST_BAD;
                    else
                    begin
                        x_stk_we    = 1'b1;
                        x_stk_addr  = d_reg[STK_AW-1:0] - STK_AW'(1);
                        x_need_iter = (w_reg[0][4:0] == OP_SQRT);
                        x_sqrt      = 1'b1;
                        x_val       = {31'd0, (w_reg[0][4:0] == OP_COS) && (top_reg == '0)};
                    end
                end
                OP_OUT:
                begin
                    if (d_reg == '0)
                        x_err = ST_UNDER;
                    else
                        x_ov = 1'b1;
                end
                OP_IN:
                begin
                    if (d_reg[STK_DW-1])
                        x_err = ST_OVER;
                    else
                    begin
                        x_stk_we = 1'b1;
                        x_val    = inv_reg;
                        x_depth  = d_reg + STK_DW'(1);
                    end
                end
                OP_DUMP:
                begin
                    x_halt = 1'b0;
                end
                OP_JMP:
                begin
                    if (tgt_bad)
                        x_err = ST_BAD;
                    else
                        x_ip = w_reg[1][CODE_AW-1:0];
                end
                OP_JA, OP_JAE, OP_JB, OP_JBE, OP_JE, OP_JNE:
                begin
                    if (d_reg < STK_DW'(2))
                        x_err = ST_UNDER;
                    else if (take && tgt_bad)
                        x_err = ST_BAD;
                    else
                    begin
                        x_depth = d_reg - STK_DW'(2);
                        x_ip    = take ? w_reg[1][CODE_AW-1:0] : ip_reg + CODE_AW'(2);
                    end
                end
                OP_CALL:
                begin
                    if (tgt_bad)
                        x_err = ST_BAD;
                    else if (rd_reg[RS_DW-1])
                        x_err = ST_CALL;
                    else
                    begin
                        x_rs_we = 1'b1;
                        x_rd    = rd_reg + RS_DW'(1);
                        x_ip    = w_reg[1][CODE_AW-1:0];
                    end
                end
                OP_RET:
                begin
                    if (rd_reg == '0)
                        x_err = ST_CALL;
                    else
                    begin
                        x_rd = rd_reg - RS_DW'(1);
                        x_ip = rtop_reg;
                    end
                end
                default:
                begin
                    x_err = ST_BAD;
                end
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = (req_type == REQ_EXEC && !stopped_reg) ? S_FETCH : S_RESP;
            end
            S_FETCH:
            begin
                if (cnt_reg == 3'd4)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (x_err != ST_OK)
                    state_next = S_RESP;
                else if (x_need_ram)
                    state_next = S_RAMRD;
                else if (x_need_iter)
                    state_next = S_ITER;
                else
                    state_next = S_RESP;
            end
            S_RAMRD:
            begin
                state_next = S_RESP;
            end
            S_ITER:
            begin
                if (iter_done)
                    state_next = S_RESP;
            end
            S_RESP:
            begin
                if (res_ready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs of the sequencer: memory addresses, commit strobe, unit start, stack write data
    always_comb
    begin
        code_raddr = ip_reg + CODE_AW'(cnt_reg[1:0]);
        stk_raddr  = (cnt_reg == 3'd0) ? d_reg[STK_AW-1:0] - STK_AW'(1)
                                       : d_reg[STK_AW-1:0] - STK_AW'(2);
        commit = ((state_reg == S_EXEC) && !(x_err == ST_OK && (x_need_ram || x_need_iter)))
              || (state_reg == S_RAMRD)
              || ((state_reg == S_ITER) && iter_done);
        iter_ctl.start   = (state_reg == S_EXEC) && (x_err == ST_OK) && x_need_iter;
        iter_ctl.is_sqrt = x_sqrt;
        ram_val   = ram_vq ? ram_q : 32'd0;
        if (state_reg == S_RAMRD)
            stk_wdata = ram_val;
        else if (state_reg == S_ITER)
            stk_wdata = iter_res;
        else
            stk_wdata = x_val;
    end

    smstep_iter u_iter (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (iter_ctl),
        .opa    (x_sqrt ? top_reg : sec_reg),
        .opb    (top_reg),
        .done   (iter_done),
        .result (iter_res)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            ip_reg      <= '0;
            entry_reg   <= '0;
            d_reg       <= '0;
            rd_reg      <= '0;
            stopped_reg <= 1'b0;
            status_reg  <= ST_OK;
            ov_reg      <= 1'b0;
            ram_vld_reg <= '0;
            for (int i = 0; i < NUM_REGS; i++)
                gp_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                entry_reg <= cfg_wdata;
            if (state_reg == S_FETCH)
                cnt_reg <= cnt_reg + 3'd1;
            else
                cnt_reg <= '0;
            if (accept)
            begin
                ov_reg <= 1'b0;
                if (req_type == REQ_RESTART)
                begin
                    ip_reg      <= entry_reg;
                    d_reg       <= '0;
                    rd_reg      <= '0;
                    stopped_reg <= 1'b0;
                    status_reg  <= ST_OK;
                end
            end
            if (commit)
            begin
                if (x_err != ST_OK)
                begin
                    stopped_reg <= 1'b1;
                    status_reg  <= x_err;
                end
                else
                begin
                    stopped_reg <= x_halt;
                    ov_reg      <= x_ov;
                    ip_reg      <= x_ip;
                    d_reg       <= x_depth;
                    rd_reg      <= x_rd;
                    if (x_gp_we)
                        gp_reg[ridx] <= top_reg;
                    if (x_ram_we)
                        ram_vld_reg[opsum[RAM_AW-1:0]] <= 1'b1;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            inv_reg  <= in_value;
            oval_reg <= '0;
        end
        if (commit && x_err == ST_OK && x_ov)
            oval_reg <= top_reg;
        if (state_reg == S_FETCH)
        begin
            if (cnt_reg != 3'd0)
                w_reg[cnt_reg[1:0] - 2'd1] <= code_q;
            if (cnt_reg == 3'd1)
            begin
                top_reg  <= stk_q;
                rtop_reg <= rs_q;
            end
            if (cnt_reg == 3'd2)
                sec_reg <= stk_q;
        end
    end

    // code memory: written by code-write requests, read during fetch
    always_ff @(posedge clk)
    begin
        if (accept && req_type == REQ_WRITE)
            code_mem[code_addr] <= code_word;
        code_q <= code_mem[code_raddr];
    end

    // data stack
    always_ff @(posedge clk)
    begin
        if (commit && x_err == ST_OK && x_stk_we)
            stk_mem[x_stk_addr] <= stk_wdata;
        stk_q <= stk_mem[stk_raddr];
    end

    // return stack
    always_ff @(posedge clk)
    begin
        if (commit && x_err == ST_OK && x_rs_we)
            rs_mem[rd_reg[RS_AW-1:0]] <= ip_reg + CODE_AW'(2);
        rs_q <= rs_mem[rd_reg[RS_AW-1:0] - RS_AW'(1)];
    end

    // data RAM; unwritten words read as zero through the valid bits
    always_ff @(posedge clk)
    begin
        if (commit && x_err == ST_OK && x_ram_we)
            ram_mem[opsum[RAM_AW-1:0]] <= top_reg;
        ram_q  <= ram_mem[opsum[RAM_AW-1:0]];
        ram_vq <= ram_vld_reg[opsum[RAM_AW-1:0]];
    end

endmodule
